// ----- rtl/core/i2cms_pkg.sv -----
// Package for the I2C master bit sequencer: command codes, shared types and constants.
// Used by the step logic, the top level and the testbench. No dependencies.
package i2cms_pkg;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } op_t;

  localparam logic [7:0] MSB_MASK = 8'h80;

  // Phase on which a bit cycle ends, and the last bit of a byte or of a one-bit acknowledge.
  localparam logic [1:0] PHASE_LAST_BIT = 2'd2;
  localparam logic [2:0] LAST_BIT_BYTE  = 3'd7;
  localparam logic [2:0] LAST_BIT_ONE   = 3'd0;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       ack_level;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    op_t        active_command;
    logic [1:0] phase;
    logic [2:0] bit_index;
    logic [7:0] transmit_shift;
    logic [7:0] receive_shift;
    logic       scl_level;
    logic       sda_level;
    logic       ack_bit;
  } seq_state_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
  } result_t;

endpackage

// ----- rtl/core/i2cms_if.sv -----
// Valid/ready channel interfaces of the I2C master bit sequencer.
// One interface for the tick input channel and one for the status result channel.
interface i2cms_tick_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] write_data;
  logic       ack_level;
  logic       sda_sample;

  modport source (output valid, output operation, output write_data, output ack_level,
                  output sda_sample, input ready);
  modport sink (input valid, input operation, input write_data, input ack_level,
                input sda_sample, output ready);
endinterface

interface i2cms_status_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_received;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output read_byte, output ack_received, input ready);
  modport sink (input valid, input scl_out, input sda_out, input busy_res,
                input done_res, input read_byte, input ack_received, output ready);
endinterface

// ----- rtl/core/i2cms_step.sv -----
// Combinational next-state logic of the I2C master bit sequencer: one pin step per tick.
// Depends on i2cms_pkg.
module i2cms_step (
  input  i2cms_pkg::seq_state_t state,
  input  i2cms_pkg::cmd_t       cmd,
  output i2cms_pkg::seq_state_t state_next,
  output i2cms_pkg::result_t    result
);

  always_comb begin
    i2cms_pkg::seq_state_t s;
    logic                  done;
    logic                  cycle_step;
    logic [2:0]            last_bit;

    s          = state;
    done       = 1'b0;
    cycle_step = 1'b0;
    last_bit   = i2cms_pkg::LAST_BIT_ONE;

    // A command is taken only when idle; it also performs its first step now.
    if (s.active_command == i2cms_pkg::OP_NONE && cmd.operation >= i2cms_pkg::OP_START &&
        cmd.operation <= i2cms_pkg::OP_RACK) begin
      s.active_command = i2cms_pkg::op_t'(cmd.operation);
      s.phase          = 2'd0;
      s.bit_index      = 3'd0;
      if (cmd.operation == i2cms_pkg::OP_WRITE) begin
        s.transmit_shift = cmd.write_data;
      end else if (cmd.operation == i2cms_pkg::OP_SACK) begin
        s.transmit_shift = cmd.ack_level ? i2cms_pkg::MSB_MASK : 8'h00;
      end else if (cmd.operation == i2cms_pkg::OP_READ) begin
        s.receive_shift = 8'h00;
      end
    end

    case (s.active_command)
      i2cms_pkg::OP_NONE: begin
      end
      i2cms_pkg::OP_START: begin
        case (s.phase)
          2'd0: s.sda_level = 1'b1;
          2'd1: s.scl_level = 1'b1;
          2'd2: s.sda_level = 1'b0;
          default: begin
            s.scl_level = 1'b0;
            done        = 1'b1;
          end
        endcase
        s.phase = s.phase + 2'd1;
      end
      i2cms_pkg::OP_STOP: begin
        case (s.phase)
          2'd0: s.sda_level = 1'b0;
          2'd1: s.scl_level = 1'b1;
          default: begin
            s.sda_level = 1'b1;
            done        = 1'b1;
          end
        endcase
        s.phase = s.phase + 2'd1;
      end
      i2cms_pkg::OP_WRITE, i2cms_pkg::OP_SACK: begin
        cycle_step = 1'b1;
        last_bit   = (s.active_command == i2cms_pkg::OP_WRITE) ?
                     i2cms_pkg::LAST_BIT_BYTE : i2cms_pkg::LAST_BIT_ONE;
        case (s.phase)
          2'd0: s.sda_level = s.transmit_shift[7];
          2'd1: s.scl_level = 1'b1;
          default: begin
            s.scl_level      = 1'b0;
            s.transmit_shift = {s.transmit_shift[6:0], 1'b0};
          end
        endcase
      end
      i2cms_pkg::OP_READ, i2cms_pkg::OP_RACK: begin
        cycle_step = 1'b1;
        last_bit   = (s.active_command == i2cms_pkg::OP_READ) ?
                     i2cms_pkg::LAST_BIT_BYTE : i2cms_pkg::LAST_BIT_ONE;
        case (s.phase)
          2'd0: s.sda_level = 1'b1;
          2'd1: begin
            s.scl_level = 1'b1;
            if (s.active_command == i2cms_pkg::OP_READ) begin
              if (cmd.sda_sample) begin
                s.receive_shift = s.receive_shift | (i2cms_pkg::MSB_MASK >> s.bit_index);
              end
            end else begin
              s.ack_bit = cmd.sda_sample;
            end
          end
          default: s.scl_level = 1'b0;
        endcase
      end
      default: done = 1'b1;
    endcase

    // Three-phase bit cycle shared by the byte and acknowledge commands.
    if (cycle_step) begin
      if (s.phase < i2cms_pkg::PHASE_LAST_BIT) begin
        s.phase = s.phase + 2'd1;
      end else begin
        s.phase = 2'd0;
        if (s.bit_index >= last_bit) begin
          done = 1'b1;
        end else begin
          s.bit_index = s.bit_index + 3'd1;
        end
      end
    end

    if (done) begin
      s.active_command = i2cms_pkg::OP_NONE;
      s.phase          = 2'd0;
      s.bit_index      = 3'd0;
    end

    state_next          = s;
    result.scl_out      = s.scl_level;
    result.sda_out      = s.sda_level;
    result.busy_res     = (s.active_command != i2cms_pkg::OP_NONE);
    result.done_res     = done;
    result.read_byte    = s.receive_shift;
    result.ack_received = s.ack_bit;
  end

endmodule

// ----- rtl/core/i2c_master_bit_sequencer_core.sv -----
// Top level of the I2C master bit sequencer: input register, step logic, result register.
// Depends on i2cms_pkg, the channel interfaces in i2cms_if.sv and i2cms_step.
//
// Each tick transaction on the tick channel performs one pin write of an I2C master
// sequence and yields exactly one status transaction. The block sustains one transaction
// per clock cycle while the status channel does not stall. A tick accepted on
// the tick channel is held in the input register, and its status is then loaded
// into the result register, from which it is offered on the status channel. The
// sequencer state advances when the input register holds a tick and the result
// register is empty or being drained, so a stall on the status channel holds the
// state and back-pressures the tick channel. A command (start, stop, write byte,
// read byte, send acknowledge, read acknowledge) is taken only
// while no sequence is in progress and does its first pin write on that same tick; a command
// offered while busy is ignored. Bytes go most significant bit first, SDA and SCL are
// open-drain with 1 meaning released, and on reads SDA is sampled on the tick that raises
// SCL. Start takes 4 ticks, stop 3, a byte 24, and each acknowledge 3. After reset both
// lines read released and the block is idle.
module i2c_master_bit_sequencer_core (
  input  logic                  clk,
  input  logic                  rst,
  i2cms_tick_if.sink            tick,
  i2cms_status_if.source        status
);

  logic                  in_valid;
  i2cms_pkg::cmd_t       in_cmd;
  logic                  res_valid;
  i2cms_pkg::result_t    res;
  i2cms_pkg::seq_state_t seq_state;
  i2cms_pkg::seq_state_t seq_state_next;
  i2cms_pkg::result_t    step_result;
  logic                  advance;

  // The result register can take a new value when it is empty or is being taken.
  assign advance    = !res_valid || status.ready;
  assign tick.ready = !in_valid || advance;

  i2cms_step u_step (
    .state      (seq_state),
    .cmd        (in_cmd),
    .state_next (seq_state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      res_valid <= 1'b0;
      seq_state <= '{active_command: i2cms_pkg::OP_NONE, phase: 2'd0, bit_index: 3'd0,
                     transmit_shift: 8'h00, receive_shift: 8'h00, scl_level: 1'b1,
                     sda_level: 1'b1, ack_bit: 1'b0};
    end else begin
      if (tick.ready) begin
        in_valid <= tick.valid;
      end
      if (advance) begin
        res_valid <= in_valid;
      end
      if (advance && in_valid) begin
        seq_state <= seq_state_next;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      in_cmd <= '{operation: tick.operation, write_data: tick.write_data,
                  ack_level: tick.ack_level, sda_sample: tick.sda_sample};
    end
    if (advance && in_valid) begin
      res <= step_result;
    end
  end

  assign status.valid        = res_valid;
  assign status.scl_out      = res.scl_out;
  assign status.sda_out      = res.sda_out;
  assign status.busy_res     = res.busy_res;
  assign status.done_res     = res.done_res;
  assign status.read_byte    = res.read_byte;
  assign status.ack_received = res.ack_received;

endmodule

// ----- rtl/core/i2cms_checker.sv -----
// Port-level checks for the I2C master bit sequencer, bound to its top level.
// Depends on the top level's status channel; no package use.
module i2cms_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       scl_out,
  input logic       sda_out,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_byte,
  input logic       ack_received
);

  logic prev_busy;
  logic prev_scl;
  logic prev_sda;
  logic res_take;

  assign res_take = res_valid && res_ready;

  // Last status transaction taken; reset state is idle with both lines released.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_busy <= 1'b0;
      prev_scl  <= 1'b1;
      prev_sda  <= 1'b1;
    end else if (res_take) begin
      prev_busy <= busy_res;
      prev_scl  <= scl_out;
      prev_sda  <= sda_out;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("status valid right after reset");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    res_take && done_res |-> prev_busy)
    else $error("done without a sequence in progress");

  a_idle_holds_pins: assert property (@(posedge clk) disable iff (rst)
    res_take && !prev_busy && !busy_res && !done_res |->
      scl_out == prev_scl && sda_out == prev_sda)
    else $error("pins moved on an idle tick");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(read_byte) && $stable(ack_received))
    else $error("stalled status transaction changed");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (status.valid),
  .res_ready    (status.ready),
  .scl_out      (status.scl_out),
  .sda_out      (status.sda_out),
  .busy_res     (status.busy_res),
  .done_res     (status.done_res),
  .read_byte    (status.read_byte),
  .ack_received (status.ack_received)
);

// ----- verif/tb_i2c_master_bit_sequencer_core.sv -----
// Self-checking testbench for the I2C master bit sequencer core.
// Depends on i2cms_pkg, the channel interfaces in i2cms_if.sv and the core itself.
// Drives tick transactions, predicts each status transaction and compares them in order.
module tb_i2c_master_bit_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation code 7 is not a command; the core must treat it like an idle tick.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int RANDOM_TICKS   = 400;
  localparam int SEGMENTS       = 4;
  localparam int HOLDOFF_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  // One row of the directed stimulus. When has_fixed is set, the status for this tick is
  // simple enough to write down by hand and is used instead of the predicted one.
  typedef struct {
    logic [2:0]         op;
    logic [7:0]         wdata;
    logic               ack_lvl;
    logic               sda_in;
    bit                 has_fixed;
    i2cms_pkg::result_t fixed;
  } stim_row_t;

  // The testbench's own copy of the sequencer state.
  typedef struct {
    i2cms_pkg::op_t cmd;
    logic [1:0]     phase;
    logic [2:0]     bit_idx;
    logic [7:0]     tx_byte;
    logic [7:0]     rx_byte;
    logic           scl;
    logic           sda;
    logic           ack;
  } line_model_t;

  logic clk;
  logic rst;

  i2cms_tick_if   tick_ch();
  i2cms_status_if status_ch();

  i2c_master_bit_sequencer_core dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .status (status_ch)
  );

  line_model_t        model;
  i2cms_pkg::result_t expected_status[$];
  stim_row_t          directed_rows[$];

  // Shared traffic controls: idle_on enables random gaps on both channels, and a bump of
  // holdoff_requests asks the status side for one long stall.
  bit idle_on;
  int holdoff_requests;
  int holdoffs_granted;

  int ticks_sent;
  int commands_taken;
  int bytes_taken;
  int status_checked;
  int mismatches;
  int idle_cycles;

  // 20 ns clock period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length for either channel: mostly none or short, occasionally long.
  function automatic int gap_len();
    int roll;
    if (!idle_on) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Advance the line model by one tick and return the status the core should report.
  // A command is taken only while idle and performs its first pin write on the same tick.
  // Write byte and send acknowledge share the shift-out path (send acknowledge is a
  // one-bit write of the acknowledge level); read byte and read acknowledge share the
  // sample path, with SDA sampled on the tick that raises SCL.
  function automatic i2cms_pkg::result_t step_line_model(input logic [2:0] op,
                                                         input logic [7:0] wdata,
                                                         input logic ack_lvl,
                                                         input logic sda_in);
    i2cms_pkg::result_t r;
    logic               done;
    logic               bit_cycle;
    logic [2:0]         last_bit;
    done      = 1'b0;
    bit_cycle = 1'b0;
    if (model.cmd == i2cms_pkg::OP_NONE && op >= i2cms_pkg::OP_START &&
        op <= i2cms_pkg::OP_RACK) begin
      model.cmd     = i2cms_pkg::op_t'(op);
      model.phase   = 2'd0;
      model.bit_idx = 3'd0;
      commands_taken++;
      if (op == i2cms_pkg::OP_WRITE) begin
        model.tx_byte = wdata;
        bytes_taken++;
      end else if (op == i2cms_pkg::OP_SACK) begin
        model.tx_byte = ack_lvl ? i2cms_pkg::MSB_MASK : 8'h00;
      end else if (op == i2cms_pkg::OP_READ) begin
        model.rx_byte = 8'h00;
        bytes_taken++;
      end
    end
    last_bit = (model.cmd == i2cms_pkg::OP_WRITE || model.cmd == i2cms_pkg::OP_READ) ?
               i2cms_pkg::LAST_BIT_BYTE : i2cms_pkg::LAST_BIT_ONE;
    case (model.cmd)
      i2cms_pkg::OP_START: begin
        case (model.phase)
          2'd0: model.sda = 1'b1;
          2'd1: model.scl = 1'b1;
          2'd2: model.sda = 1'b0;
          default: begin
            model.scl = 1'b0;
            done      = 1'b1;
          end
        endcase
        model.phase = model.phase + 2'd1;
      end
      i2cms_pkg::OP_STOP: begin
        case (model.phase)
          2'd0: model.sda = 1'b0;
          2'd1: model.scl = 1'b1;
          default: begin
            model.sda = 1'b1;
            done      = 1'b1;
          end
        endcase
        model.phase = model.phase + 2'd1;
      end
      i2cms_pkg::OP_WRITE, i2cms_pkg::OP_SACK: begin
        bit_cycle = 1'b1;
        case (model.phase)
          2'd0: model.sda = model.tx_byte[7];
          2'd1: model.scl = 1'b1;
          default: begin
            model.scl     = 1'b0;
            model.tx_byte = model.tx_byte << 1;
          end
        endcase
      end
      i2cms_pkg::OP_READ, i2cms_pkg::OP_RACK: begin
        bit_cycle = 1'b1;
        case (model.phase)
          2'd0: model.sda = 1'b1;
          2'd1: begin
            model.scl = 1'b1;
            if (model.cmd == i2cms_pkg::OP_READ) begin
              if (sda_in) begin
                model.rx_byte = model.rx_byte | (i2cms_pkg::MSB_MASK >> model.bit_idx);
              end
            end else begin
              model.ack = sda_in;
            end
          end
          default: model.scl = 1'b0;
        endcase
      end
      default: ;
    endcase
    // Each bit takes three ticks; the sequence ends after the last bit's third tick.
    if (bit_cycle) begin
      if (model.phase < i2cms_pkg::PHASE_LAST_BIT) begin
        model.phase = model.phase + 2'd1;
      end else begin
        model.phase = 2'd0;
        if (model.bit_idx >= last_bit) begin
          done = 1'b1;
        end else begin
          model.bit_idx = model.bit_idx + 3'd1;
        end
      end
    end
    if (done) begin
      model.cmd     = i2cms_pkg::OP_NONE;
      model.phase   = 2'd0;
      model.bit_idx = 3'd0;
    end
    r.scl_out      = model.scl;
    r.sda_out      = model.sda;
    r.busy_res     = (model.cmd != i2cms_pkg::OP_NONE);
    r.done_res     = done;
    r.read_byte    = model.rx_byte;
    r.ack_received = model.ack;
    return r;
  endfunction

  // Offer one tick and hold it until the core takes it. The handshake is sampled right
  // after the rising edge, so ready and valid hold their values from before the edge.
  // When no gap follows, valid simply stays high for the next tick.
  task automatic send_tick(input logic [2:0] op, input logic [7:0] wdata, input logic ack_lvl,
                           input logic sda_in, input bit has_fixed,
                           input i2cms_pkg::result_t fixed);
    i2cms_pkg::result_t predicted;
    int                 gap;
    tick_ch.valid      <= 1'b1;
    tick_ch.operation  <= op;
    tick_ch.write_data <= wdata;
    tick_ch.ack_level  <= ack_lvl;
    tick_ch.sda_sample <= sda_in;
    @(posedge clk);
    while (!tick_ch.ready) begin
      @(posedge clk);
    end
    predicted = step_line_model(op, wdata, ack_lvl, sda_in);
    expected_status.push_back(has_fixed ? fixed : predicted);
    ticks_sent++;
    gap = gap_len();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_status.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic stim_row_t row(input logic [2:0] op, input logic [7:0] wdata,
                                    input logic ack_lvl, input logic sda_in,
                                    input bit has_fixed, input i2cms_pkg::result_t fixed);
    stim_row_t r;
    r.op        = op;
    r.wdata     = wdata;
    r.ack_lvl   = ack_lvl;
    r.sda_in    = sda_in;
    r.has_fixed = has_fixed;
    r.fixed     = fixed;
    return r;
  endfunction

  // One random unit of traffic. Most units are a whole command: the command tick, then
  // ticks until the model says the sequence is over. While busy, an occasional stray
  // command is offered and must be ignored, sometimes landing on the last step. The rest
  // are idle ticks with no operation or with the unused code.
  task automatic run_sequence();
    logic [2:0] cmd_op;
    logic [2:0] stray_op;
    logic [7:0] data;
    int         noise;
    if ($urandom_range(0, 4) == 0) begin
      noise = $urandom_range(1, 3);
      repeat (noise) begin
        stray_op = $urandom_range(0, 1) ? OP_UNUSED : i2cms_pkg::OP_NONE;
        send_tick(stray_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end else begin
      cmd_op = 3'($urandom_range(i2cms_pkg::OP_START, i2cms_pkg::OP_RACK));
      case ($urandom_range(0, 9))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom_range(0, 255));
      endcase
      send_tick(cmd_op, data, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
      while (model.cmd != i2cms_pkg::OP_NONE) begin
        stray_op = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : i2cms_pkg::OP_NONE;
        send_tick(stray_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end
  endtask

  // Status side: random stalls while idling is on, plus one long hold-off on request,
  // counted here so the tick side keeps offering and the core fills up and back-pressures.
  initial begin
    int stall_left;
    stall_left      = 0;
    status_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        status_ch.ready <= 1'b0;
      end else if (holdoffs_granted != holdoff_requests) begin
        holdoffs_granted++;
        stall_left = HOLDOFF_CYCLES;
        status_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        status_ch.ready <= 1'b0;
      end else begin
        status_ch.ready <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  // Every status transaction is compared with the oldest prediction, field by field.
  always @(posedge clk) begin
    i2cms_pkg::result_t want;
    if (!rst && status_ch.valid && status_ch.ready) begin
      status_checked++;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Status transaction %0d arrived with nothing expected", status_checked);
        end
      end else begin
        want = expected_status.pop_front();
        if (status_ch.scl_out !== want.scl_out || status_ch.sda_out !== want.sda_out ||
            status_ch.busy_res !== want.busy_res || status_ch.done_res !== want.done_res ||
            status_ch.read_byte !== want.read_byte ||
            status_ch.ack_received !== want.ack_received) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch on status %0d: expected scl=%b sda=%b busy=%b done=%b",
                     status_checked, want.scl_out, want.sda_out, want.busy_res,
                     want.done_res);
            $display("    expected byte=%02h ack=%b", want.read_byte, want.ack_received);
            $display("    got scl=%b sda=%b busy=%b done=%b byte=%02h ack=%b",
                     status_ch.scl_out, status_ch.sda_out, status_ch.busy_res,
                     status_ch.done_res, status_ch.read_byte, status_ch.ack_received);
          end
        end
      end
    end
  end

  // The run is stuck if neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (status_ch.valid && status_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d statuses outstanding",
                 idle_cycles, expected_status.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int seg;
    int target;
    rst                = 1'b1;
    tick_ch.valid      = 1'b0;
    tick_ch.operation  = i2cms_pkg::OP_NONE;
    tick_ch.write_data = 8'h00;
    tick_ch.ack_level  = 1'b0;
    tick_ch.sda_sample = 1'b0;
    idle_on            = 1'b1;
    holdoff_requests   = 0;
    holdoffs_granted   = 0;
    ticks_sent         = 0;
    commands_taken     = 0;
    bytes_taken        = 0;
    status_checked     = 0;
    mismatches         = 0;

    // Reset state: both lines released, idle, nothing received.
    model.cmd     = i2cms_pkg::OP_NONE;
    model.phase   = 2'd0;
    model.bit_idx = 3'd0;
    model.tx_byte = 8'h00;
    model.rx_byte = 8'h00;
    model.scl     = 1'b1;
    model.sda     = 1'b1;
    model.ack     = 1'b0;

    // Directed ticks. Fixed statuses are {scl, sda, busy, done, read byte, ack}.
    // An idle tick right after reset shows both lines released.
    directed_rows.push_back(row(i2cms_pkg::OP_NONE, 8'h00, 1'b0, 1'b0, 1'b1,
                                i2cms_pkg::result_t'({1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0})));
    // Start condition: SDA released, SCL released, SDA low, SCL low.
    directed_rows.push_back(row(i2cms_pkg::OP_START, 8'h00, 1'b0, 1'b0, 1'b1,
                                i2cms_pkg::result_t'({1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0})));
    directed_rows.push_back(row(i2cms_pkg::OP_NONE, 8'h00, 1'b0, 1'b0, 1'b1,
                                i2cms_pkg::result_t'({1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0})));
    directed_rows.push_back(row(i2cms_pkg::OP_NONE, 8'h00, 1'b0, 1'b0, 1'b1,
                                i2cms_pkg::result_t'({1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0})));
    directed_rows.push_back(row(i2cms_pkg::OP_NONE, 8'h00, 1'b0, 1'b0, 1'b1,
                                i2cms_pkg::result_t'({1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0})));
    // The unused code with every other field high is just an idle tick; pins hold.
    directed_rows.push_back(row(OP_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1,
                                i2cms_pkg::result_t'({1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0})));
    // Send a not-acknowledge; a stop offered mid-sequence and a write offered on the
    // last step are both ignored.
    directed_rows.push_back(row(i2cms_pkg::OP_SACK, 8'h00, 1'b1, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(i2cms_pkg::OP_STOP, 8'h00, 1'b0, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(i2cms_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0, '0));
    // Read acknowledge sampling a low SDA, with a read byte offered while busy.
    directed_rows.push_back(row(i2cms_pkg::OP_RACK, 8'h00, 1'b0, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(i2cms_pkg::OP_NONE, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(i2cms_pkg::OP_READ, 8'h00, 1'b0, 1'b1, 1'b0, '0));
    // Read acknowledge sampling a high SDA.
    directed_rows.push_back(row(i2cms_pkg::OP_RACK, 8'hFF, 1'b1, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(i2cms_pkg::OP_NONE, 8'h00, 1'b0, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(i2cms_pkg::OP_NONE, 8'h00, 1'b0, 1'b1, 1'b0, '0));
    // Send an acknowledge (SDA driven low).
    directed_rows.push_back(row(i2cms_pkg::OP_SACK, 8'hFF, 1'b0, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(i2cms_pkg::OP_NONE, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(i2cms_pkg::OP_NONE, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    // Stop condition with the unused code mid-sequence and a start on the last step.
    directed_rows.push_back(row(i2cms_pkg::OP_STOP, 8'hFF, 1'b1, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(OP_UNUSED, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(i2cms_pkg::OP_START, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(i2cms_pkg::OP_NONE, 8'h00, 1'b0, 1'b0, 1'b0, '0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_tick(directed_rows[i].op, directed_rows[i].wdata, directed_rows[i].ack_lvl,
                directed_rows[i].sda_in, directed_rows[i].has_fixed, directed_rows[i].fixed);
    end

    // Random traffic in segments: gaps on both sides, then back to back with no gaps,
    // then back to back against a long status hold-off, then gaps again after the tick
    // side has paused until every outstanding status has come back.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: idle_on = 1'b1;
        1: idle_on = 1'b0;
        2: holdoff_requests++;
        default: begin
          tick_ch.valid <= 1'b0;
          wait_drained();
          idle_on = 1'b1;
        end
      endcase
      target = ticks_sent + RANDOM_TICKS / SEGMENTS;
      while (ticks_sent < target) begin
        run_sequence();
      end
    end

    tick_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks carrying %0d accepted commands, %0d of them byte transfers.",
             ticks_sent, commands_taken, bytes_taken);
    $display("Checked %0d status transactions with %0d mismatches.", status_checked, mismatches);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
